FILE: src/lsedq_pkg.sv
package lsedq_pkg;

    localparam int IN_W              = 16;
    localparam int ERR_W             = 24;
    localparam int BYTE_W            = 8;
    localparam int WHITE_W           = 16;
    localparam int LANES             = 3;
    localparam int MUL_BYTE          = 255;
    localparam int FRACTION_BITS_DEF = 14;

    typedef enum logic {
        OP_WHITE = 1'b0,
        OP_RGB   = 1'b1
    } t_op;

    typedef struct packed {
        logic                    operation;
        logic                    first_pixel;
        logic signed [IN_W-1:0]  red_in;
        logic signed [IN_W-1:0]  green_in;
        logic signed [IN_W-1:0]  blue_in;
        logic signed [IN_W-1:0]  white_in;
    } t_in_beat;

    typedef struct packed {
        logic [WHITE_W-1:0] white_level;
        logic [BYTE_W-1:0]  red_byte;
        logic [BYTE_W-1:0]  green_byte;
        logic [BYTE_W-1:0]  blue_byte;
    } t_out_beat;

    // control shared by all lanes
    typedef struct packed {
        logic s1_load;
        logic s2_load;
        logic rgb;
        logic first;
    } t_lane_ctl;

endpackage

FILE: src/lsedq_lane.sv
module lsedq_lane
    import lsedq_pkg::*;
#(
    parameter int FRAC_BITS = FRACTION_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_lane_ctl              i_ctl,
    input  logic signed [IN_W-1:0] i_value,
    output logic [BYTE_W-1:0]      o_byte
);

    localparam int PROD_W = IN_W + BYTE_W;
    localparam int SUM_W  = ((PROD_W > ERR_W) ? PROD_W : ERR_W) + 1;
    localparam int TOP_W  = FRAC_BITS + BYTE_W + 2;
    localparam int CMP_W  = ((SUM_W > TOP_W) ? SUM_W : TOP_W) + 1;
    localparam int DIF_W  = CMP_W + 1;

    localparam logic signed [CMP_W-1:0] CLAMP_HI = CMP_W'(MUL_BYTE) <<< FRAC_BITS;
    localparam logic signed [CMP_W-1:0] HALF     = CMP_W'(1) <<< (FRAC_BITS - 1);
    localparam logic signed [DIF_W-1:0] E_MAX    = (DIF_W'(1) <<< (ERR_W - 1)) - DIF_W'(1);
    localparam logic signed [DIF_W-1:0] E_MIN    = -E_MAX - DIF_W'(1);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [PROD_W-1:0] val_ext;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [ERR_W-1:0]  n_err;
    logic signed [ERR_W-1:0]  err_used;
    logic signed [CMP_W-1:0]  corrected;
    logic signed [CMP_W-1:0]  clamped;
    logic signed [CMP_W-1:0]  rnd_sum;
    logic [BYTE_W-1:0]        rounded;
    logic signed [DIF_W-1:0]  diff;
    logic signed [DIF_W-1:0]  step_back;

    // value * 255 as (value << 8) - value
    always_comb begin
        val_ext = PROD_W'(i_value);
        n_prod  = (val_ext <<< BYTE_W) - val_ext;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.s1_load) begin
            r_prod <= n_prod;
        end
    end

    // error feedback loop: add, clamp, round, saturate, all combinational
    always_comb begin
        err_used  = i_ctl.first ? '0 : r_err;
        corrected = CMP_W'(r_prod) + CMP_W'(err_used);
        if (corrected < 0) begin
            clamped = '0;
        end else if (corrected > CLAMP_HI) begin
            clamped = CLAMP_HI;
        end else begin
            clamped = corrected;
        end
        rnd_sum   = clamped + HALF;
        rounded   = BYTE_W'(rnd_sum >>> FRAC_BITS);
        step_back = DIF_W'(signed'({1'b0, rounded, {FRAC_BITS{1'b0}}}));
        diff      = DIF_W'(corrected) - step_back;
        if (diff > E_MAX) begin
            n_err = ERR_W'(E_MAX);
        end else if (diff < E_MIN) begin
            n_err = ERR_W'(E_MIN);
        end else begin
            n_err = ERR_W'(diff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err <= '0;
        end else if (i_ctl.s2_load && i_ctl.rgb) begin
            r_err <= n_err;
        end
    end

    assign o_byte = rounded;

endmodule

FILE: src/led_strand_error_diffusion_quantizer_core.sv
// Pipeline: input beat accepted into the product stage, then the
//   diffusion/output register drives o_valid.
// Throughput: one beat per cycle while the sink holds i_ready; the per-channel
//   error loop (add, clamp, round, saturate) is combinational in each lane.
// Reset (synchronous, active low) clears both pipeline valids and all three
//   channel errors; no clearing pass.
module led_strand_error_diffusion_quantizer_core
    import lsedq_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_data
);

    localparam int LVL_W  = FRACTION_BITS + 1;
    localparam int WCMP_W = ((IN_W > LVL_W) ? IN_W : LVL_W) + 1;
    localparam int WPRD_W = LVL_W + WHITE_W;
    localparam logic signed [WCMP_W-1:0] ONE_S = WCMP_W'(1) <<< FRACTION_BITS;

    logic             r_s1_valid;
    logic             r_s1_op;
    logic             r_s1_first;
    logic [LVL_W-1:0] r_s1_white;
    logic [LVL_W-1:0] n_s1_white;
    logic             r_s2_valid;
    t_out_beat        r_out;
    t_out_beat        n_out;

    logic                    s1_go;
    logic                    s2_go;
    logic signed [WCMP_W-1:0] lvl_ext;
    logic [WPRD_W-1:0]       white_prod;
    t_lane_ctl               lane_ctl;
    logic signed [IN_W-1:0]  lane_val  [LANES];
    logic [BYTE_W-1:0]       lane_byte [LANES];

    assign s2_go   = !r_s2_valid || i_ready;
    assign s1_go   = !r_s1_valid || s2_go;
    assign o_ready = s1_go;
    assign o_valid = r_s2_valid;
    assign o_data  = r_out;

    assign lane_ctl.s1_load = i_valid && s1_go;
    assign lane_ctl.s2_load = r_s1_valid && s2_go;
    assign lane_ctl.rgb     = (r_s1_op == OP_RGB);
    assign lane_ctl.first   = r_s1_first;

    assign lane_val[0] = i_data.red_in;
    assign lane_val[1] = i_data.green_in;
    assign lane_val[2] = i_data.blue_in;

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        lsedq_lane #(
            .FRAC_BITS(FRACTION_BITS)
        ) u_lane (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl  (lane_ctl),
            .i_value(lane_val[g]),
            .o_byte (lane_byte[g])
        );
    end

    // white level clamped to 0..one ahead of the scale
    always_comb begin
        lvl_ext = WCMP_W'(i_data.white_in);
        if (lvl_ext < 0) begin
            n_s1_white = '0;
        end else if (lvl_ext > ONE_S) begin
            n_s1_white = LVL_W'(ONE_S);
        end else begin
            n_s1_white = LVL_W'(lvl_ext);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_go) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lane_ctl.s1_load) begin
            r_s1_op    <= i_data.operation;
            r_s1_first <= i_data.first_pixel;
            r_s1_white <= n_s1_white;
        end
    end

    // merge: white scale or lane bytes, the other side zeroed
    always_comb begin
        white_prod = {r_s1_white, {WHITE_W{1'b0}}} - WPRD_W'(r_s1_white);
        n_out      = '0;
        if (lane_ctl.rgb) begin
            n_out.red_byte   = lane_byte[0];
            n_out.green_byte = lane_byte[1];
            n_out.blue_byte  = lane_byte[2];
        end else begin
            n_out.white_level = WHITE_W'(white_prod >> FRACTION_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_go) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (lane_ctl.s2_load) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: tb/lsedq_dither_checker.sv
module lsedq_dither_checker
    import lsedq_pkg::*;
#(
    parameter int FRAC_BITS = FRACTION_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_beat  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_beat i_out_data,
    output int        o_mismatches,
    output int        o_outstanding
);

    localparam longint ONE     = longint'(1) << FRAC_BITS;
    localparam longint HALF    = ONE / 2;
    localparam longint FULL    = longint'(MUL_BYTE) * ONE;
    localparam longint ERR_HI  = (longint'(1) << (ERR_W - 1)) - 1;
    localparam longint ERR_LO  = -(longint'(1) << (ERR_W - 1));

    logic signed [ERR_W-1:0] lane_err [LANES];
    t_out_beat               expected_pixels [$];

    // one channel of the diffusion loop; updates that lane's carried error
    function automatic logic [BYTE_W-1:0] dither_lane(int lane, logic signed [IN_W-1:0] lvl);
        longint corrected;
        longint clamped;
        longint rounded;
        longint resid;
        corrected = longint'(lvl) * MUL_BYTE + longint'(lane_err[lane]);
        clamped   = corrected;
        if (clamped < 0) clamped = 0;
        if (clamped > FULL) clamped = FULL;
        rounded = (clamped + HALF) >>> FRAC_BITS;
        resid   = corrected - rounded * ONE;
        if (resid > ERR_HI) resid = ERR_HI;
        if (resid < ERR_LO) resid = ERR_LO;
        lane_err[lane] = resid[ERR_W-1:0];
        return rounded[BYTE_W-1:0];
    endfunction

    function automatic t_out_beat quantize_beat(t_in_beat b);
        t_out_beat r;
        longint    lvl;
        r = '0;
        if (b.operation == OP_WHITE) begin
            lvl = longint'(b.white_in);
            if (lvl < 0) lvl = 0;
            if (lvl > ONE) lvl = ONE;
            lvl = (lvl * 65535) >>> FRAC_BITS;
            r.white_level = lvl[WHITE_W-1:0];
        end else begin
            if (b.first_pixel) begin
                for (int k = 0; k < LANES; k++) begin
                    lane_err[k] = '0;
                end
            end
            r.red_byte   = dither_lane(0, b.red_in);
            r.green_byte = dither_lane(1, b.green_in);
            r.blue_byte  = dither_lane(2, b.blue_in);
        end
        return r;
    endfunction

    task automatic check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_beat want;
        t_out_beat pred;
        if (!i_rst_n) begin
            for (int k = 0; k < LANES; k++) begin
                lane_err[k] = '0;
            end
            expected_pixels.delete();
            o_mismatches = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t unexpected output beat: expected none, actual %h",
                             $time, i_out_data);
                    o_mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    check_field("white_level", want.white_level, i_out_data.white_level);
                    check_field("red_byte", want.red_byte, i_out_data.red_byte);
                    check_field("green_byte", want.green_byte, i_out_data.green_byte);
                    check_field("blue_byte", want.blue_byte, i_out_data.blue_byte);
                end
            end
            if (i_in_valid && i_in_ready) begin
                pred            = quantize_beat(i_in_data);
                expected_pixels = {expected_pixels, pred};
            end
        end
        o_outstanding <= expected_pixels.size();
    end

endmodule

FILE: tb/tb_led_strand_error_diffusion_quantizer_core.sv
module tb_led_strand_error_diffusion_quantizer_core;
    import lsedq_pkg::*;

    localparam int RANDOM_BEATS = 1625;
    localparam int CALM_TAIL    = 150;
    localparam int STALL_LIMIT  = 1000;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_ready;
    t_in_beat  i_data  = '0;
    logic      o_valid;
    logic      i_ready = 1'b0;
    t_out_beat o_data;

    logic      idle_en = 1'b1;
    int        stall_left = 0;
    int        quiet_cycles = 0;
    int        mismatches;
    int        outstanding;

    always #10 i_clk = ~i_clk;

    led_strand_error_diffusion_quantizer_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    lsedq_dither_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_in_data     (i_data),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_out_data    (o_data),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // sink back-pressure in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_ready    <= 1'b0;
        end else if (idle_en && $urandom_range(0, 3) == 0) begin
            stall_left <= $urandom_range(0, 9);
            i_ready    <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    function automatic logic signed [IN_W-1:0] pick_level();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return IN_W'($urandom_range(0, 16384));
            6:                return IN_W'($urandom);
            7:                return IN_W'(int'($urandom_range(0, 128)) - 64);
            8:                return IN_W'($urandom_range(16320, 16448));
            default:          return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        endcase
    endfunction

    function automatic t_in_beat noise_beat();
        t_in_beat b;
        b = t_in_beat'($bits(t_in_beat)'({$urandom, $urandom, $urandom}));
        return b;
    endfunction

    task automatic send_beat(input t_in_beat b);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    task automatic send_white(input logic signed [IN_W-1:0] lvl, input logic fp);
        t_in_beat b;
        b             = noise_beat();
        b.operation   = OP_WHITE;
        b.first_pixel = fp;
        b.white_in    = lvl;
        send_beat(b);
    endtask

    task automatic send_rgb(input logic fp, input logic signed [IN_W-1:0] r,
                            input logic signed [IN_W-1:0] g,
                            input logic signed [IN_W-1:0] bl);
        t_in_beat b;
        b             = noise_beat();
        b.operation   = OP_RGB;
        b.first_pixel = fp;
        b.red_in      = r;
        b.green_in    = g;
        b.blue_in     = bl;
        send_beat(b);
    endtask

    initial begin
        int sent;
        int run;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // white clamp edges
        send_white(16'sh8000, 1'b0);
        send_white(-16'sd1, 1'b0);
        send_white(16'sd0, 1'b0);
        send_white(16'sd1, 1'b0);
        send_white(16'sd8192, 1'b0);
        send_white(16'sd16383, 1'b0);
        send_white(16'sd16384, 1'b0);
        send_white(16'sd16385, 1'b0);
        send_white(16'sh7fff, 1'b0);
        // exact halves round up
        send_rgb(1'b1, 16'sd8192, 16'sd8192, 16'sd8192);
        send_rgb(1'b0, 16'sd0, 16'sd16384, 16'sh8000);
        // over-full drives error to positive saturation
        send_rgb(1'b1, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_rgb(1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_rgb(1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        // white beat with first flag must leave the carried error alone
        send_white(16'sd4096, 1'b1);
        send_rgb(1'b0, 16'sd0, 16'sd100, 16'sd8192);
        // negative saturation
        send_rgb(1'b1, 16'sh8000, 16'sh8000, 16'sh8000);
        send_rgb(1'b0, 16'sh8000, 16'sh8000, 16'sh8000);
        send_rgb(1'b0, 16'sh8000, 16'sh8000, 16'sh8000);
        send_rgb(1'b0, 16'sd16384, 16'sd0, 16'sd16384);
        send_rgb(1'b1, 16'sh7fff, 16'sh8000, 16'sd8192);
        send_rgb(1'b0, 16'sd100, 16'sd200, 16'sd300);
        send_rgb(1'b1, 16'sd16384, 16'sd16384, 16'sd16384);

        sent = 0;
        while (sent < RANDOM_BEATS) begin
            if (sent < RANDOM_BEATS - CALM_TAIL) begin
                idle_en <= ($urandom_range(0, 2) != 0);
            end else begin
                idle_en <= 1'b0;
            end
            if ($urandom_range(0, 5) == 0) begin
                send_white(pick_level(), 1'($urandom));
                sent++;
            end else begin
                // one strand: first pixel, then a run, now and then a stray restart
                run = $urandom_range(1, 40);
                send_rgb(1'b1, pick_level(), pick_level(), pick_level());
                sent++;
                for (int k = 1; k < run; k++) begin
                    send_rgb($urandom_range(0, 19) == 0, pick_level(), pick_level(),
                             pick_level());
                    sent++;
                end
            end
        end
        i_valid <= 1'b0;
        idle_en <= 1'b0;

        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: filelist.f
src/lsedq_pkg.sv
src/lsedq_lane.sv
src/led_strand_error_diffusion_quantizer_core.sv
tb/lsedq_dither_checker.sv
tb/tb_led_strand_error_diffusion_quantizer_core.sv
